// ----- hw/rtl/pcsm_pkg.sv -----
// Shared types and constants of the p-code stack machine step unit.
`default_nettype none
package pcsm_pkg;
  localparam int ADDR_W = 10;
  localparam int WORD_W = 32;
  localparam int TOP_W  = 11;

  typedef enum logic [3:0] {
    OP_LIT  = 4'd0,
    OP_LOD  = 4'd1,
    OP_STO  = 4'd2,
    OP_CAL  = 4'd3,
    OP_INT  = 4'd4,
    OP_JMP  = 4'd5,
    OP_JPC  = 4'd6,
    OP_OPR  = 4'd7,
    OP_LEA  = 4'd8,
    OP_LODI = 4'd9,
    OP_STOI = 4'd10,
    OP_REL  = 4'd11
  } op_t;

  localparam logic signed [WORD_W-1:0] OPR_RET   = 32'sd0;
  localparam logic signed [WORD_W-1:0] OPR_NEG   = 32'sd1;
  localparam logic signed [WORD_W-1:0] OPR_ADD   = 32'sd2;
  localparam logic signed [WORD_W-1:0] OPR_SUB   = 32'sd3;
  localparam logic signed [WORD_W-1:0] OPR_MUL   = 32'sd4;
  localparam logic signed [WORD_W-1:0] OPR_DIV   = 32'sd5;
  localparam logic signed [WORD_W-1:0] OPR_ODD   = 32'sd6;
  localparam logic signed [WORD_W-1:0] OPR_EQL   = 32'sd8;
  localparam logic signed [WORD_W-1:0] OPR_NEQ   = 32'sd9;
  localparam logic signed [WORD_W-1:0] OPR_LSS   = 32'sd10;
  localparam logic signed [WORD_W-1:0] OPR_GEQ   = 32'sd11;
  localparam logic signed [WORD_W-1:0] OPR_GTR   = 32'sd12;
  localparam logic signed [WORD_W-1:0] OPR_LEQ   = 32'sd13;
  localparam logic signed [WORD_W-1:0] OPR_PRINT = 32'sd14;
  localparam logic signed [WORD_W-1:0] OPR_NL    = 32'sd15;
  localparam logic signed [WORD_W-1:0] OPR_READ  = 32'sd16;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_ADDR = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic walk_rd;
    logic walk_ld;
    logic rd1;
    logic ld_x;
    logic rd2;
    logic ld_y;
    logic eval;
    logic div_start;
    logic div_ld;
    logic wr;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic walk_end;
    logic fail;
    logic is_div;
    logic has_wr;
    logic div_done;
    logic wr_last;
    logic out_free;
  } sts_t;
endpackage
`default_nettype wire

// ----- hw/rtl/pcsm_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module pcsm_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [pcsm_pkg::WORD_W-1:0] dividend,
  input  wire logic [pcsm_pkg::WORD_W-1:0] divisor,
  output logic                             done,
  output logic [pcsm_pkg::WORD_W-1:0]      quot
);
  logic [pcsm_pkg::WORD_W-1:0] q_r, rem_r, d_r;
  logic [4:0]                  cnt_r;
  logic                        run_r, done_r;
  logic [pcsm_pkg::WORD_W:0]   sh;
  logic                        ge;

  assign sh = {rem_r, q_r[pcsm_pkg::WORD_W-1]};
  assign ge = sh >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (&cnt_r) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (run_r) begin
      rem_r <= ge ? pcsm_pkg::WORD_W'(sh - {1'b0, d_r}) : sh[pcsm_pkg::WORD_W-1:0];
      q_r   <= {q_r[pcsm_pkg::WORD_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;
endmodule
`default_nettype wire

// ----- hw/rtl/pcsm_dpath.sv -----
// Datapath: machine registers, stack memory, decode, ALU and result register.
`default_nettype none
module pcsm_dpath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire pcsm_pkg::cmd_t                     cmd,
  output pcsm_pkg::sts_t                          sts,
  input  wire logic [3:0]                         in_operation,
  input  wire logic [3:0]                         in_level,
  input  wire logic signed [pcsm_pkg::WORD_W-1:0] in_operand,
  input  wire logic signed [pcsm_pkg::WORD_W-1:0] in_read_value,
  input  wire logic                               out_ready,
  output logic                                    out_valid,
  output logic [pcsm_pkg::ADDR_W-1:0]             out_next_pc,
  output logic                                    out_print_valid,
  output logic signed [pcsm_pkg::WORD_W-1:0]      out_print_value,
  output logic                                    out_newline,
  output logic                                    out_read_taken,
  output logic [1:0]                              out_status
);
  localparam int AW = pcsm_pkg::ADDR_W;
  localparam int DW = pcsm_pkg::WORD_W;
  localparam int TW = pcsm_pkg::TOP_W;

  logic [DW-1:0]                 stack_mem [2**AW];
  logic [DW-1:0]                 mem_q_r;
  logic [AW-1:0]                 clr_r, pc_r, fb_r;
  logic signed [TW-1:0]          t_r;
  pcsm_pkg::op_t                 op_r;
  logic signed [DW-1:0]          a_r, rv_r, x_r, y_r, r_r;
  logic [DW-1:0]                 ptr_r;
  logic [3:0]                    cnt_r;
  logic [1:0]                    wk_r;
  pcsm_pkg::status_t             err_r;

  logic                          out_valid_r, pv_r, nl_r, rt_r;
  logic [AW-1:0]                 npc_out_r;
  logic signed [DW-1:0]          pval_r;
  logic [1:0]                    st_out_r;

  logic [AW-1:0]                 b, tp1, tm1_a, pc1, ra, wa, wa_c;
  logic [DW-1:0]                 wd, wd_c;
  logic                          we;
  logic signed [DW+1:0]          idx, nt34;
  logic                          idx_ok, nt_ok, ptr_bad, t_neg, t_full, t_lt1;
  logic signed [TW-1:0]          tm1, tm2;
  logic                          s_ret, s_neg, s_odd, s_bin, s_div, s_print, s_nl, s_read;
  pcsm_pkg::status_t             st_c;
  logic [1:0]                    nw_c;
  logic signed [DW-1:0]          alu_c;
  logic [2*DW-1:0]               prod;
  logic [AW-1:0]                 npc_c, nb_c;
  logic signed [TW-1:0]          nt_c;
  logic [DW-1:0]                 dvd, dvs, quot;
  logic                          div_done;

  assign b       = ptr_r[AW-1:0];
  assign ptr_bad = ptr_r[DW-1:AW] != '0;
  assign tp1     = t_r[AW-1:0] + AW'(1);
  assign tm1     = t_r - TW'(1);
  assign tm2     = t_r - TW'(2);
  assign tm1_a   = tm1[AW-1:0];
  assign pc1     = pc_r + AW'(1);
  assign idx     = $signed({(DW+2-AW)'(0), b}) + (DW+2)'(a_r);
  assign idx_ok  = idx[DW+1:AW] == '0;
  assign nt34    = (op_r == pcsm_pkg::OP_INT) ? (DW+2)'(t_r) + (DW+2)'(a_r)
                                              : (DW+2)'(t_r) - (DW+2)'(a_r);
  assign nt_ok   = (nt34[DW+1:AW] == '0) || (&nt34);
  assign t_neg   = t_r[TW-1];
  assign t_full  = t_r == TW'(2**AW - 1);
  assign t_lt1   = t_r < TW'(1);

  always_comb begin
    s_ret   = a_r == pcsm_pkg::OPR_RET;
    s_neg   = a_r == pcsm_pkg::OPR_NEG;
    s_odd   = a_r == pcsm_pkg::OPR_ODD;
    s_bin   = a_r inside {[pcsm_pkg::OPR_ADD:pcsm_pkg::OPR_DIV],
                          [pcsm_pkg::OPR_EQL:pcsm_pkg::OPR_LEQ]};
    s_div   = a_r == pcsm_pkg::OPR_DIV;
    s_print = a_r == pcsm_pkg::OPR_PRINT;
    s_nl    = a_r == pcsm_pkg::OPR_NL;
    s_read  = a_r == pcsm_pkg::OPR_READ;
  end

  // Status after all operand reads.
  always_comb begin
    st_c = pcsm_pkg::ST_OK;
    case (op_r)
      pcsm_pkg::OP_LIT: if (t_full) st_c = pcsm_pkg::ST_RANGE;
      pcsm_pkg::OP_LOD: if (ptr_bad || !idx_ok || t_full) st_c = pcsm_pkg::ST_RANGE;
      pcsm_pkg::OP_STO: if (ptr_bad || !idx_ok || t_neg) st_c = pcsm_pkg::ST_RANGE;
      pcsm_pkg::OP_LEA: if (ptr_bad || t_full) st_c = pcsm_pkg::ST_RANGE;
      pcsm_pkg::OP_CAL:
        if (ptr_bad || t_r >= TW'(2**AW - 3)) st_c = pcsm_pkg::ST_RANGE;
      pcsm_pkg::OP_INT, pcsm_pkg::OP_REL: if (!nt_ok) st_c = pcsm_pkg::ST_RANGE;
      pcsm_pkg::OP_JPC: if (t_neg) st_c = pcsm_pkg::ST_RANGE;
      pcsm_pkg::OP_OPR: begin
        if (s_ret) begin
          if (fb_r >= AW'(2**AW - 2) || x_r[DW-1:AW] != '0) st_c = pcsm_pkg::ST_RANGE;
        end else if (s_neg || s_odd || s_print) begin
          if (t_neg) st_c = pcsm_pkg::ST_RANGE;
        end else if (s_bin) begin
          if (t_lt1) st_c = pcsm_pkg::ST_RANGE;
          else if (s_div && y_r == '0) st_c = pcsm_pkg::ST_DIV_ZERO;
        end else if (s_read) begin
          if (t_full) st_c = pcsm_pkg::ST_RANGE;
        end
      end
      pcsm_pkg::OP_LODI: begin
        if (t_neg) st_c = pcsm_pkg::ST_RANGE;
        else if (t_r == '0 || $unsigned(x_r) > DW'(tm1[AW-1:0]))
          st_c = pcsm_pkg::ST_BAD_ADDR;
      end
      pcsm_pkg::OP_STOI: begin
        if (t_lt1) st_c = pcsm_pkg::ST_RANGE;
        else if (t_r == TW'(1) || $unsigned(x_r) > DW'(tm2[AW-1:0]))
          st_c = pcsm_pkg::ST_BAD_ADDR;
      end
      default: st_c = pcsm_pkg::ST_OK;
    endcase
  end

  assign prod = x_r * y_r;

  always_comb begin
    alu_c = '0;
    if (s_neg) alu_c = -x_r;
    else if (s_odd) alu_c = x_r[0] ? (x_r[DW-1] ? -DW'(1) : DW'(1)) : '0;
    else begin
      case (a_r)
        pcsm_pkg::OPR_ADD: alu_c = x_r + y_r;
        pcsm_pkg::OPR_SUB: alu_c = x_r - y_r;
        pcsm_pkg::OPR_MUL: alu_c = prod[DW-1:0];
        pcsm_pkg::OPR_EQL: alu_c = DW'(x_r == y_r);
        pcsm_pkg::OPR_NEQ: alu_c = DW'(x_r != y_r);
        pcsm_pkg::OPR_LSS: alu_c = DW'(x_r < y_r);
        pcsm_pkg::OPR_GEQ: alu_c = DW'(x_r >= y_r);
        pcsm_pkg::OPR_GTR: alu_c = DW'(y_r < x_r);
        pcsm_pkg::OPR_LEQ: alu_c = DW'(y_r >= x_r);
        default:           alu_c = '0;
      endcase
    end
  end

  // Read addresses for the chain walk and the two operand reads.
  always_comb begin
    ra = t_r[AW-1:0];
    if (cmd.walk_rd) ra = b;
    else if (cmd.rd1) begin
      case (op_r)
        pcsm_pkg::OP_LOD:  ra = idx[AW-1:0];
        pcsm_pkg::OP_STOI: ra = tm1_a;
        pcsm_pkg::OP_OPR:  ra = s_ret ? fb_r + AW'(1) : (s_bin ? tm1_a : t_r[AW-1:0]);
        default:           ra = t_r[AW-1:0];
      endcase
    end else begin
      case (op_r)
        pcsm_pkg::OP_LODI: ra = x_r[AW-1:0];
        pcsm_pkg::OP_OPR:  ra = s_ret ? fb_r + AW'(2) : t_r[AW-1:0];
        default:           ra = t_r[AW-1:0];
      endcase
    end
  end

  // Stack writes and next machine state.
  always_comb begin
    nw_c  = 2'd0;
    wa_c  = tp1;
    wd_c  = r_r;
    npc_c = pc1;
    nb_c  = fb_r;
    nt_c  = t_r;
    case (op_r)
      pcsm_pkg::OP_LIT: begin
        nw_c = 2'd1; wd_c = a_r; nt_c = t_r + TW'(1);
      end
      pcsm_pkg::OP_LOD: begin
        nw_c = 2'd1; wd_c = x_r; nt_c = t_r + TW'(1);
      end
      pcsm_pkg::OP_STO: begin
        nw_c = 2'd1; wa_c = idx[AW-1:0]; wd_c = x_r; nt_c = tm1;
      end
      pcsm_pkg::OP_LEA: begin
        nw_c = 2'd1; wd_c = idx[DW-1:0]; nt_c = t_r + TW'(1);
      end
      pcsm_pkg::OP_CAL: begin
        nw_c  = 2'd3;
        npc_c = a_r[AW-1:0];
        nb_c  = tp1;
        case (wk_r)
          2'd0:    begin wa_c = tp1;                wd_c = DW'(b);    end
          2'd1:    begin wa_c = tp1 + AW'(1);       wd_c = DW'(fb_r); end
          default: begin wa_c = tp1 + AW'(2);       wd_c = DW'(pc1);  end
        endcase
      end
      pcsm_pkg::OP_INT, pcsm_pkg::OP_REL: nt_c = nt34[TW-1:0];
      pcsm_pkg::OP_JMP: npc_c = a_r[AW-1:0];
      pcsm_pkg::OP_JPC: begin
        if (x_r == '0) npc_c = a_r[AW-1:0];
        nt_c = tm1;
      end
      pcsm_pkg::OP_OPR: begin
        if (s_ret) begin
          npc_c = y_r[AW-1:0];
          nb_c  = x_r[AW-1:0];
          nt_c  = $signed({1'b0, fb_r}) - TW'(1);
        end else if (s_neg || s_odd) begin
          nw_c = 2'd1; wa_c = t_r[AW-1:0];
        end else if (s_bin) begin
          nw_c = 2'd1; wa_c = tm1_a; nt_c = tm1;
        end else if (s_print) begin
          nt_c = tm1;
        end else if (s_read) begin
          nw_c = 2'd1; wd_c = rv_r; nt_c = t_r + TW'(1);
        end
      end
      pcsm_pkg::OP_LODI: begin
        nw_c = 2'd1; wa_c = t_r[AW-1:0]; wd_c = y_r;
      end
      pcsm_pkg::OP_STOI: begin
        nw_c = 2'd1; wa_c = x_r[AW-1:0]; wd_c = y_r; nt_c = tm2;
      end
      default: nw_c = 2'd0;
    endcase
  end

  assign we = cmd.clr_wr | cmd.wr;
  assign wa = cmd.clr_wr ? clr_r : wa_c;
  assign wd = cmd.clr_wr ? '0 : wd_c;

  always_ff @(posedge clk) begin
    if (we) stack_mem[wa] <= wd;
    mem_q_r <= stack_mem[ra];
  end

  assign dvd = x_r[DW-1] ? DW'(-x_r) : DW'(x_r);
  assign dvs = y_r[DW-1] ? DW'(-y_r) : DW'(y_r);

  pcsm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quot     (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      pc_r        <= '0;
      fb_r        <= '0;
      t_r         <= TW'(2);
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_r <= clr_r + AW'(1);
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
        if (err_r == pcsm_pkg::ST_OK) begin
          pc_r <= npc_c;
          fb_r <= nb_c;
          t_r  <= nt_c;
        end
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= pcsm_pkg::op_t'(in_operation);
      a_r   <= in_operand;
      rv_r  <= in_read_value;
      ptr_r <= DW'(fb_r);
      cnt_r <= (pcsm_pkg::op_t'(in_operation) inside
                {pcsm_pkg::OP_LOD, pcsm_pkg::OP_STO, pcsm_pkg::OP_CAL, pcsm_pkg::OP_LEA})
               ? in_level : 4'd0;
    end
    if (cmd.walk_ld) begin
      ptr_r <= mem_q_r;
      cnt_r <= cnt_r - 4'd1;
    end
    if (cmd.ld_x) x_r <= mem_q_r;
    if (cmd.ld_y) y_r <= mem_q_r;
    if (cmd.eval) begin
      err_r <= st_c;
      r_r   <= alu_c;
      wk_r  <= 2'd0;
    end
    if (cmd.div_ld) r_r <= (x_r[DW-1] ^ y_r[DW-1]) ? -quot : quot;
    if (cmd.wr) wk_r <= wk_r + 2'd1;
    if (cmd.commit) begin
      if (err_r == pcsm_pkg::ST_OK) begin
        npc_out_r <= npc_c;
        pv_r      <= op_r == pcsm_pkg::OP_OPR && s_print;
        pval_r    <= (op_r == pcsm_pkg::OP_OPR && s_print) ? x_r : '0;
        nl_r      <= op_r == pcsm_pkg::OP_OPR && s_nl;
        rt_r      <= op_r == pcsm_pkg::OP_OPR && s_read;
      end else begin
        npc_out_r <= pc_r;
        pv_r      <= 1'b0;
        pval_r    <= '0;
        nl_r      <= 1'b0;
        rt_r      <= 1'b0;
      end
      st_out_r <= err_r;
    end
  end

  always_comb begin
    sts.clr_last = &clr_r;
    sts.walk_end = (cnt_r == 4'd0) || ptr_bad;
    sts.fail     = st_c != pcsm_pkg::ST_OK;
    sts.is_div   = op_r == pcsm_pkg::OP_OPR && s_div;
    sts.has_wr   = nw_c != 2'd0;
    sts.div_done = div_done;
    sts.wr_last  = wk_r == nw_c - 2'd1;
    sts.out_free = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_next_pc     = npc_out_r;
  assign out_print_valid = pv_r;
  assign out_print_value = pval_r;
  assign out_newline     = nl_r;
  assign out_read_taken  = rt_r;
  assign out_status      = st_out_r;
endmodule
`default_nettype wire

// ----- hw/rtl/pcsm_ctrl.sv -----
// Controller: sequences stack clear, chain walk, reads, divide, writes and commit.
`default_nettype none
module pcsm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire pcsm_pkg::sts_t sts,
  output pcsm_pkg::cmd_t      cmd
);
  typedef enum logic [11:0] {
    S_CLEAR  = 12'b000000000001,
    S_IDLE   = 12'b000000000010,
    S_WALK   = 12'b000000000100,
    S_WALKW  = 12'b000000001000,
    S_RD1    = 12'b000000010000,
    S_RD1W   = 12'b000000100000,
    S_RD2    = 12'b000001000000,
    S_RD2W   = 12'b000010000000,
    S_EVAL   = 12'b000100000000,
    S_DIV    = 12'b001000000000,
    S_WRITE  = 12'b010000000000,
    S_COMMIT = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.walk_end) state_nxt = S_RD1;
        else begin
          cmd.walk_rd = 1'b1;
          state_nxt   = S_WALKW;
        end
      end
      S_WALKW: begin
        cmd.walk_ld = 1'b1;
        state_nxt   = S_WALK;
      end
      S_RD1: begin
        cmd.rd1   = 1'b1;
        state_nxt = S_RD1W;
      end
      S_RD1W: begin
        cmd.ld_x  = 1'b1;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        cmd.rd2   = 1'b1;
        state_nxt = S_RD2W;
      end
      S_RD2W: begin
        cmd.ld_y  = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.fail) state_nxt = S_COMMIT;
        else if (sts.is_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else if (sts.has_wr) state_nxt = S_WRITE;
        else state_nxt = S_COMMIT;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_ld = 1'b1;
          state_nxt  = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.wr = 1'b1;
        if (sts.wr_last) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end
endmodule
`default_nettype wire

// ----- hw/rtl/pcsm_stack_machine_step_unit.sv -----
// Top level of the p-code stack machine step unit.
//
// Channel  Direction  Ports
// in       request    in_valid/in_ready, in_operation, in_level, in_operand, in_read_value
// out      result     out_valid/out_ready, out_next_pc, out_print_valid, out_print_value,
//                     out_newline, out_read_taken, out_status
//
// After reset the stack memory is cleared, one cell a cycle, with in_ready low.
// One request at a time on the single-port stack memory: a read per static-chain level,
// two operand reads, an optional serial divide and up to 3 stack writes, then commit.
// The result sits in an output register; the next request is taken while it waits,
// and only its commit stalls on a full output register.
`default_nettype none
module pcode_stack_machine_step_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [3:0]                         in_operation,
  input  wire logic [3:0]                         in_level,
  input  wire logic signed [pcsm_pkg::WORD_W-1:0] in_operand,
  input  wire logic signed [pcsm_pkg::WORD_W-1:0] in_read_value,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [pcsm_pkg::ADDR_W-1:0]             out_next_pc,
  output logic                                    out_print_valid,
  output logic signed [pcsm_pkg::WORD_W-1:0]      out_print_value,
  output logic                                    out_newline,
  output logic                                    out_read_taken,
  output logic [1:0]                              out_status
);
  pcsm_pkg::cmd_t cmd;
  pcsm_pkg::sts_t sts;

  pcsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcsm_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_operation),
    .in_level        (in_level),
    .in_operand      (in_operand),
    .in_read_value   (in_read_value),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_next_pc     (out_next_pc),
    .out_print_valid (out_print_valid),
    .out_print_value (out_print_value),
    .out_newline     (out_newline),
    .out_read_taken  (out_read_taken),
    .out_status      (out_status)
  );

`ifndef SYNTHESIS
  a_mem_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr_wr, cmd.walk_rd, cmd.rd1, cmd.rd2, cmd.wr}))
    else $error("stack memory port used twice");
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> sts.out_free)
    else $error("commit over an untaken result");
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while busy");
`endif
endmodule
`default_nettype wire
